[hdl/rpvg_pkg.sv]
//------------------------------------------------------------------------------
// rpvg_pkg
// Shared types, constants and helpers of the regular polygon vertex generator.
//------------------------------------------------------------------------------
`default_nettype none

package rpvg_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int MAX_SIDES_DEF   = 64;
	localparam int CORDIC_ITER_DEF = 16;
	localparam int ATAN_ENTRIES    = 24;
	localparam int CORDIC_GAIN     = 652032874;
	localparam int IDX_W           = 16;
	localparam int ANG_W           = 16;
	localparam int DIV_STEPS       = ANG_W + 1;
	localparam int CW              = 34;
	localparam int SUM_W           = 20;
	localparam int EXT_W           = ((SUM_W > COORD_WIDTH) ? SUM_W : COORD_WIDTH) + 1;

	typedef struct packed {
		logic        [15:0] first_index;
		logic        [15:0] last_index;
		logic        [15:0] radius;
		logic        [15:0] angle_offset;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic signed [15:0] z_offset;
	} rpvg_req_t;

	typedef struct packed {
		logic        [15:0]            vertex_index;
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
		logic signed [COORD_WIDTH-1:0] z_coord;
		logic                          last_vertex;
		logic                          status;
	} rpvg_vtx_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_SPAN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROT,
		ST_MULX,
		ST_MULZ,
		ST_OUT,
		ST_ERR
	} rpvg_state_t;

	// atan(2^-i), 2^32 per turn
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [EXT_W-1:0] ve;
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] lo;
		ve = EXT_W'(v);
		hi = (EXT_W'(1) <<< (COORD_WIDTH - 1)) - EXT_W'(1);
		lo = -hi - EXT_W'(1);
		if (ve > hi) begin
			ve = hi;
		end else if (ve < lo) begin
			ve = lo;
		end
		return ve[COORD_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/rpvg_div.sv]
//------------------------------------------------------------------------------
// rpvg_div
// Bit-serial restoring divider: one turn (65536) divided by the side count.
//------------------------------------------------------------------------------
`default_nettype none

module rpvg_div
	import rpvg_pkg::*;
#(
	parameter int NW = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NW-1:0]        divisor,
	output logic                      done,
	output logic      [DIV_STEPS-1:0] quot,
	output logic      [NW-1:0]        rem
);

	localparam int SC_W = $clog2(DIV_STEPS + 1);

	logic               busy_q;
	logic               done_q;
	logic [SC_W-1:0]    cnt_q;
	logic [NW-1:0]      div_q;
	logic [NW-1:0]      rem_q;
	logic [DIV_STEPS-1:0] quot_q;
	logic [NW:0]        trial;
	logic               fits;

	// dividend is a single one in its top bit
	assign trial = {rem_q, (cnt_q == '0)};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + SC_W'(1);
				if (cnt_q == SC_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_STEPS-2:0], fits};
			rem_q  <= fits ? NW'(trial - {1'b0, div_q}) : trial[NW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[hdl/rpvg_cordic.sv]
//------------------------------------------------------------------------------
// rpvg_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle, Q1.30.
//------------------------------------------------------------------------------
`default_nettype none

module rpvg_cordic
	import rpvg_pkg::*;
#(
	parameter int ITER = CORDIC_ITER_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic        [ANG_W-1:0] angle,
	output logic                      done,
	output logic signed [CW-1:0]      cos_val,
	output logic signed [CW-1:0]      sin_val
);

	localparam int N     = (ITER > ATAN_ENTRIES) ? ATAN_ENTRIES : ITER;
	localparam int CNT_W = $clog2(N);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     i_q;
	logic                 flip_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;

	logic [31:0]          w;
	logic                 flip;
	logic [31:0]          w_fold;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [CW-1:0] at;

	// fold left half plane onto the right one
	assign w      = {angle, 16'h0000};
	assign flip   = w[31] ^ w[30];
	assign w_fold = {w[31] ^ flip, w[30:0]};

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({{(CW - 32){1'b0}}, atan_turns(5'(i_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + CNT_W'(1);
				if (i_q == CNT_W'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q    <= CW'(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= $signed({{(CW - 32){w_fold[31]}}, w_fold});
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

[hdl/rpvg_scale.sv]
//------------------------------------------------------------------------------
// rpvg_scale
// Shared multiplier: trig value times radius, rounded, offset and saturated.
//------------------------------------------------------------------------------
`default_nettype none

module rpvg_scale
	import rpvg_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          load,
	input  wire logic signed [CW-1:0]          trig,
	input  wire logic        [15:0]            radius,
	input  wire logic signed [15:0]            offset,
	output logic signed      [COORD_WIDTH-1:0] coord
);

	localparam int PW = CW + 17;

	logic signed [PW-1:0]    prod_q;
	logic signed [PW-1:0]    rnd;
	logic signed [PW-1:0]    scaled;
	logic signed [SUM_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PW'(trig) * PW'($signed({1'b0, radius}));
		end
	end

	assign rnd    = prod_q + $signed(PW'(64'd1 << 29));
	assign scaled = rnd >>> 30;
	assign sum    = $signed(scaled[SUM_W-1:0]) + SUM_W'(offset);
	assign coord  = sat_coord(sum);

endmodule

`default_nettype wire

[hdl/regular_polygon_vertex_generator.sv]
//------------------------------------------------------------------------------
// regular_polygon_vertex_generator
// Emits the vertices of a regular n-gon in the XZ plane, one per transfer.
//------------------------------------------------------------------------------
// A request is taken only while the block is idle. The index range is put in
// order; a span of one index gives nothing, a span over MAX_SIDES gives one
// error transfer. Otherwise a bit-serial divide of one turn by n comes first,
// then each vertex goes through the single CORDIC stage and the shared
// multiplier, and the next vertex starts only once the last one is loaded
// into the result register. The result register lets the last vertex wait
// while the next request is taken.
//------------------------------------------------------------------------------
`default_nettype none

module regular_polygon_vertex_generator
	import rpvg_pkg::*;
#(
	parameter int MAX_SIDES         = MAX_SIDES_DEF,
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire rpvg_req_t req,
	output logic           vtx_valid,
	input  wire logic      vtx_stall,
	output rpvg_vtx_t      vtx
);

	localparam int NW = $clog2(MAX_SIDES + 1);

	rpvg_state_t state_q, state_d;

	logic [IDX_W-1:0]       lo_q;
	logic [NW-1:0]          n_q;
	logic [NW-1:0]          t_q;
	logic [15:0]            rad_q;
	logic [ANG_W-1:0]       off_q;
	logic signed [15:0]     xo_q;
	logic signed [15:0]     yo_q;
	logic signed [15:0]     zo_q;
	logic [ANG_W-1:0]       acc_q, acc_d;
	logic [NW-1:0]          prem_q, prem_d;
	logic signed [COORD_WIDTH-1:0] xres_q;
	rpvg_vtx_t              vtx_q;
	logic                   vtx_valid_q;

	logic [IDX_W-1:0]       lo_in;
	logic [IDX_W-1:0]       hi_in;
	logic [IDX_W:0]         span;
	logic                   last;
	logic                   out_free;
	logic [NW:0]            rem_sum;

	logic                   accept, div_start, cor_start, scale_load;
	logic                   latch_req, xres_ld, vtx_ld_ok, vtx_ld_err, advance;

	logic                   div_done;
	logic [DIV_STEPS-1:0]   div_quot;
	logic [NW-1:0]          div_rem;
	logic                   cor_done;
	logic signed [CW-1:0]   cos_val;
	logic signed [CW-1:0]   sin_val;
	logic signed [COORD_WIDTH-1:0] coord;

	assign lo_in   = (req.first_index > req.last_index) ? req.last_index : req.first_index;
	assign hi_in   = (req.first_index > req.last_index) ? req.first_index : req.last_index;
	assign span    = {1'b0, hi_in} - {1'b0, lo_in} + (IDX_W + 1)'(1);
	assign last    = t_q == (n_q - NW'(1));
	assign out_free = !vtx_valid_q || !vtx_stall;
	assign rem_sum = {1'b0, prem_q} + {1'b0, div_rem};

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = state_q != ST_IDLE;

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		cor_start  = 1'b0;
		scale_load = 1'b0;
		latch_req  = 1'b0;
		xres_ld    = 1'b0;
		vtx_ld_ok  = 1'b0;
		vtx_ld_err = 1'b0;
		advance    = 1'b0;
		acc_d      = acc_q;
		prem_d     = prem_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (lo_in != hi_in)) begin
					if (span > (IDX_W + 1)'(MAX_SIDES)) begin
						state_d = ST_ERR;
					end else begin
						latch_req = 1'b1;
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					cor_start = 1'b1;
					state_d   = ST_ROT;
				end
			end
			ST_ROT: begin
				if (cor_done) begin
					state_d = ST_MULX;
				end
			end
			ST_MULX: begin
				scale_load = 1'b1;
				state_d    = ST_MULZ;
			end
			ST_MULZ: begin
				xres_ld    = 1'b1;
				scale_load = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					vtx_ld_ok = 1'b1;
					if (last) begin
						state_d = ST_IDLE;
					end else begin
						advance = 1'b1;
						if (rem_sum >= {1'b0, n_q}) begin
							prem_d = NW'(rem_sum - {1'b0, n_q});
							acc_d  = acc_q + div_quot[ANG_W-1:0] + ANG_W'(1);
						end else begin
							prem_d = rem_sum[NW-1:0];
							acc_d  = acc_q + div_quot[ANG_W-1:0];
						end
						cor_start = 1'b1;
						state_d   = ST_ROT;
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					vtx_ld_err = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vtx_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (vtx_ld_ok || vtx_ld_err) begin
				vtx_valid_q <= 1'b1;
			end else if (!vtx_stall) begin
				vtx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_req) begin
			lo_q   <= lo_in;
			n_q    <= span[NW-1:0];
			t_q    <= '0;
			rad_q  <= req.radius;
			off_q  <= req.angle_offset;
			xo_q   <= req.x_offset;
			yo_q   <= req.y_offset;
			zo_q   <= req.z_offset;
			acc_q  <= '0;
			prem_q <= '0;
		end else if (advance) begin
			t_q    <= t_q + NW'(1);
			acc_q  <= acc_d;
			prem_q <= prem_d;
		end
		if (xres_ld) begin
			xres_q <= coord;
		end
		if (vtx_ld_ok) begin
			vtx_q.vertex_index <= lo_q + IDX_W'(t_q);
			vtx_q.x_coord      <= xres_q;
			vtx_q.y_coord      <= sat_coord(SUM_W'(yo_q));
			vtx_q.z_coord      <= coord;
			vtx_q.last_vertex  <= last;
			vtx_q.status       <= STATUS_OK;
		end else if (vtx_ld_err) begin
			vtx_q.vertex_index <= '0;
			vtx_q.x_coord      <= '0;
			vtx_q.y_coord      <= '0;
			vtx_q.z_coord      <= '0;
			vtx_q.last_vertex  <= 1'b1;
			vtx_q.status       <= STATUS_SPAN;
		end
	end

	rpvg_div #(
		.NW(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (span[NW-1:0]),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	rpvg_cordic #(
		.ITER(CORDIC_ITERATIONS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (acc_d - off_q),
		.done    (cor_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	rpvg_scale u_scale (
		.clk    (clk),
		.load   (scale_load),
		.trig   ((state_q == ST_MULX) ? cos_val : sin_val),
		.radius (rad_q),
		.offset ((state_q == ST_OUT) ? zo_q : xo_q),
		.coord  (coord)
	);

	assign vtx_valid = vtx_valid_q;
	assign vtx       = vtx_q;

`ifndef SYNTHESIS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid_q && (vtx_q.status == STATUS_SPAN)) |-> vtx_q.last_vertex)
		else $error("error transfer without last_vertex");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ROT) || (state_q == ST_MULX) || (state_q == ST_MULZ) ||
		 (state_q == ST_OUT)) |-> ((t_q < n_q) && (prem_q < n_q)))
		else $error("vertex counter or phase remainder out of range");

	a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_ROT))
		else $error("CORDIC finished outside rotation state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire

[tb/regular_polygon_vertex_generator_test.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// regular_polygon_vertex_generator_test
// Self-checking bench for the CORDIC polygon vertex generator.
//------------------------------------------------------------------------------
// Requests go in from a backlog through a valid/stall driver. Each accepted
// request is expanded by a bit-exact vertex predictor: index ordering, span
// checks, phase division, CORDIC cos/sin, scaling and saturation. Every
// accepted vertex transfer is compared field by field with the oldest
// prediction. A short directed set is followed by three random phases with
// different sender/receiver idle rates, plus one long receiver hold-off.
//------------------------------------------------------------------------------

module regular_polygon_vertex_generator_test;
	import rpvg_pkg::*;

	localparam int ROT_STEPS = CORDIC_ITER_DEF;
	localparam int SIDE_MAX  = MAX_SIDES_DEF;

	localparam longint ARCTAN_STEP [0:23] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	rpvg_req_t  req;
	logic       vtx_valid;
	logic       vtx_stall;
	rpvg_vtx_t  vtx;

	rpvg_req_t  req_backlog[$];
	rpvg_vtx_t  due_vertices[$];
	rpvg_vtx_t  want;
	logic       req_fired;
	int         reqs_queued;
	int         reqs_taken;
	int         vtx_count;
	int         mismatch_count;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         hold_left;
	bit         hold_done;

	regular_polygon_vertex_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [15:0] clip_coord(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic void cordic_cos_sin(input logic [15:0] ang,
		output longint c, output longint s);
		logic [31:0] w;
		logic        flip;
		longint      x, y, z, dx, dy;
		int          i;
		w = {ang, 16'h0000};
		flip = (w[31:30] == 2'b01) || (w[31:30] == 2'b10);
		if (flip) begin
			w = w - 32'h8000_0000;
		end
		z = longint'($signed(w));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (i = 0; i < ROT_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_STEP[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_STEP[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// expands one accepted request into its vertex transfers
	function automatic void place_polygon(input rpvg_req_t r);
		logic [15:0] lo, hi, ang;
		longint      n, q, c, s, rad, xo, zo;
		rpvg_vtx_t   v;
		lo = (r.first_index > r.last_index) ? r.last_index : r.first_index;
		hi = (r.first_index > r.last_index) ? r.first_index : r.last_index;
		if (lo == hi) begin
			return;
		end
		n = longint'(hi) - longint'(lo) + 1;
		if (n > SIDE_MAX) begin
			v = '0;
			v.last_vertex = 1'b1;
			v.status = STATUS_SPAN;
			due_vertices.push_back(v);
			return;
		end
		rad = longint'(r.radius);
		xo = longint'(r.x_offset);
		zo = longint'(r.z_offset);
		for (longint t = 0; t < n; t++) begin
			q = (t << 16) / n;
			ang = q[15:0] - r.angle_offset;
			cordic_cos_sin(ang, c, s);
			v.vertex_index = lo + t[15:0];
			v.x_coord = clip_coord(((c * rad + (longint'(1) <<< 29)) >>> 30) + xo);
			v.y_coord = r.y_offset;
			v.z_coord = clip_coord(((s * rad + (longint'(1) <<< 29)) >>> 30) + zo);
			v.last_vertex = (t + 1 == n);
			v.status = STATUS_OK;
			due_vertices.push_back(v);
		end
	endfunction

	function automatic void add_req(input logic [15:0] first, input logic [15:0] last,
		input logic [15:0] radius, input logic [15:0] ang,
		input logic [15:0] xo, input logic [15:0] yo, input logic [15:0] zo);
		rpvg_req_t r;
		r.first_index = first;
		r.last_index = last;
		r.radius = radius;
		r.angle_offset = ang;
		r.x_offset = xo;
		r.y_offset = yo;
		r.z_offset = zo;
		req_backlog.push_back(r);
		reqs_queued++;
	endfunction

	// returns 0 for a request the block ignores (equal indices)
	function automatic bit queue_random_request();
		int          pick, span;
		logic [15:0] lo, hi, tmp;
		logic [15:0] rad, xo, yo, zo;
		pick = $urandom_range(99);
		if (pick < 5) begin
			lo = 16'($urandom);
			hi = lo;
		end else if (pick < 13) begin
			lo = 16'($urandom);
			hi = 16'($urandom);
		end else begin
			span = (pick < 22) ? $urandom_range(63, 12) : $urandom_range(11, 1);
			lo = 16'($urandom_range(65535 - span, 0));
			hi = lo + span[15:0];
		end
		if ($urandom_range(1)) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		if ($urandom_range(1)) begin
			rad = 16'($urandom);
			xo = 16'($urandom);
			yo = 16'($urandom);
			zo = 16'($urandom);
		end else begin
			rad = 16'($urandom_range(16'h3FFF, 0));
			xo = 16'($urandom_range(16'h3FFF, 0)) - 16'h2000;
			yo = 16'($urandom_range(16'h3FFF, 0)) - 16'h2000;
			zo = 16'($urandom_range(16'h3FFF, 0)) - 16'h2000;
		end
		add_req(lo, hi, rad, 16'($urandom), xo, yo, zo);
		return lo != hi;
	endfunction

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (reqs_taken != reqs_queued || due_vertices.size() != 0);
		@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fired)) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// vertex receiver, with one long hold-off while requests keep coming
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			vtx_stall <= 1'b1;
		end else if (!hold_done && vtx_count >= 60 && req_backlog.size() > 4) begin
			hold_done = 1'b1;
			hold_left = 700;
			vtx_stall <= 1'b1;
		end else begin
			vtx_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		req_fired <= req_valid && !req_stall;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				place_polygon(req);
				reqs_taken++;
			end
			if (vtx_valid && !vtx_stall) begin
				vtx_count++;
				if (due_vertices.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected vertex transfer idx=%0d x=%0d y=%0d z=%0d last=%0b status=%0b",
						$time, vtx.vertex_index, vtx.x_coord, vtx.y_coord, vtx.z_coord,
						vtx.last_vertex, vtx.status);
				end else begin
					want = due_vertices.pop_front();
					if (vtx.vertex_index !== want.vertex_index || vtx.x_coord !== want.x_coord ||
						vtx.y_coord !== want.y_coord || vtx.z_coord !== want.z_coord ||
						vtx.last_vertex !== want.last_vertex || vtx.status !== want.status) begin
						mismatch_count++;
						$display("%0t: vertex mismatch expected idx=%0d x=%0d y=%0d z=%0d last=%0b st=%0b",
							$time, want.vertex_index, want.x_coord, want.y_coord, want.z_coord,
							want.last_vertex, want.status);
						$display("%0t:                 actual idx=%0d x=%0d y=%0d z=%0d last=%0b st=%0b",
							$time, vtx.vertex_index, vtx.x_coord, vtx.y_coord, vtx.z_coord,
							vtx.last_vertex, vtx.status);
					end
				end
			end
		end
	end

	initial begin
		#60_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int count;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		vtx_stall = 1'b0;
		req_fired = 1'b0;
		reqs_queued = 0;
		reqs_taken = 0;
		vtx_count = 0;
		mismatch_count = 0;
		hold_left = 0;
		hold_done = 1'b0;
		send_idle_pct = 13;
		recv_idle_pct = 53;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		add_req(16'd0, 16'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd0, 16'd63, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd0, 16'd64, 16'h1234, 16'h0000, 16'h0100, 16'h0200, 16'h0300);
		add_req(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
		add_req(16'd5, 16'd5, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_req(16'd10, 16'd7, 16'h0200, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'hFFC0, 16'hFFFF, 16'h0A00, 16'h1000, 16'hF000, 16'h1000, 16'h0800);
		add_req(16'd100, 16'd103, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_req(16'd200, 16'd203, 16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
		add_req(16'd0, 16'd2, 16'h0400, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd8, 16'd15, 16'h0400, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd20, 16'd25, 16'h0400, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd30, 16'd34, 16'h0000, 16'h1234, 16'h1111, 16'h2222, 16'h3333);
		add_req(16'd1000, 16'd1002, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd7, 16'd0, 16'h7FFF, 16'hC000, 16'h8000, 16'h7FFF, 16'h0000);
		add_req(16'hFFFE, 16'hFFFF, 16'h8000, 16'h2000, 16'h0000, 16'h0000, 16'h0000);
		add_req(16'd50, 16'd113, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA);
		add_req(16'd50, 16'd114, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		count = 0;
		while (count < 73) begin
			if (queue_random_request()) begin
				count++;
			end
		end
		wait_drained();

		send_idle_pct = 53;
		recv_idle_pct = 13;
		count = 0;
		while (count < 73) begin
			if (queue_random_request()) begin
				count++;
			end
		end
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		count = 0;
		while (count < 73) begin
			if (queue_random_request()) begin
				count++;
			end
		end
		wait_drained();

		repeat (1500) @(posedge clk);
		if (mismatch_count == 0 && due_vertices.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[regular_polygon_vertex_generator.f]
hdl/rpvg_pkg.sv
hdl/rpvg_div.sv
hdl/rpvg_cordic.sv
hdl/rpvg_scale.sv
hdl/regular_polygon_vertex_generator.sv
tb/regular_polygon_vertex_generator_test.sv
